// File: rtl/hsb_pkg.sv
// shared types, constants and character helpers for the hex string parser
package hsb_pkg;

    // default store size in bytes, and the reset value of the limit register
    localparam int          MAX_BYTES_DEF = 32;
    localparam logic [5:0]  MAX_BYTES_RST = 6'd32;
    localparam logic [6:0]  LEN_CAP       = 7'd127;
    localparam int          DIGIT_W       = 5;

    // character codes
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_A_UP  = 8'h41;
    localparam logic [7:0] CH_F_UP  = 8'h46;
    localparam logic [7:0] CH_A_LO  = 8'h61;
    localparam logic [7:0] CH_F_LO  = 8'h66;
    localparam logic [7:0] CH_X_UP  = 8'h58;
    localparam logic [7:0] CH_X_LO  = 8'h78;
    localparam logic [7:0] NIB_TEN  = 8'h0A;

    // digit store entry: bit 4 flags a non-hex character
    localparam logic [DIGIT_W-1:0] DIGIT_BAD  = 5'h10;
    localparam logic [DIGIT_W-1:0] DIGIT_ZERO = 5'h00;

    // status codes of the final item
    localparam logic [2:0] ST_END    = 3'd0;
    localparam logic [2:0] ST_TRAIL  = 3'd1;
    localparam logic [2:0] ST_SPACES = 3'd2;
    localparam logic [2:0] ST_BAD    = 3'd3;
    localparam logic [2:0] ST_EMPTY  = 3'd4;

    // scan phase of the current string
    typedef enum logic [1:0] {
        PH_LEAD,
        PH_TOKEN,
        PH_TAIL
    } t_phase;

    // controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_CALC,
        S_RDH,
        S_RDL,
        S_LOAD,
        S_STAT
    } t_state;

    // controller to datapath commands
    typedef struct packed {
        logic take_char;
        logic take_end;
        logic calc;
        logic sel_hi;
        logic cap_hi;
        logic load_byte;
        logic load_stat;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic out_free;
        logic no_bytes;
        logic last_byte;
    } t_sts;

    function automatic logic is_ws(input logic [7:0] c);
        return c inside {CH_SPACE, [CH_TAB:CH_CR]};
    endfunction

    function automatic logic [DIGIT_W-1:0] to_digit(input logic [7:0] c);
        logic [7:0] v;
        v = 8'h00;
        if (c inside {[CH_A_LO:CH_F_LO]}) begin
            v = c - CH_A_LO + NIB_TEN;
        end else if (c inside {[CH_A_UP:CH_F_UP]}) begin
            v = c - CH_A_UP + NIB_TEN;
        end else if (c inside {[CH_ZERO:CH_NINE]}) begin
            v = c - CH_ZERO;
        end else begin
            return DIGIT_BAD;
        end
        return {1'b0, v[3:0]};
    endfunction

endpackage

// File: rtl/hsb_ram.sv
// generic single write port ram with registered read
module hsb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/hsb_ctrl.sv
// controller state machine for the hex string parser
module hsb_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  logic          i_end_of_string,
    input  hsb_pkg::t_sts i_sts,
    output hsb_pkg::t_cmd o_cmd
);

    hsb_pkg::t_state r_state;
    hsb_pkg::t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hsb_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            hsb_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_end_of_string) begin
                        o_cmd.take_end = 1'b1;
                        n_state        = hsb_pkg::S_CALC;
                    end else begin
                        o_cmd.take_char = 1'b1;
                    end
                end
            end
            hsb_pkg::S_CALC: begin
                o_cmd.calc = 1'b1;
                n_state    = i_sts.no_bytes ? hsb_pkg::S_STAT : hsb_pkg::S_RDH;
            end
            hsb_pkg::S_RDH: begin
                o_cmd.sel_hi = 1'b1;
                n_state      = hsb_pkg::S_RDL;
            end
            hsb_pkg::S_RDL: begin
                o_cmd.cap_hi = 1'b1;
                n_state      = hsb_pkg::S_LOAD;
            end
            hsb_pkg::S_LOAD: begin
                if (i_sts.out_free) begin
                    o_cmd.load_byte = 1'b1;
                    n_state = i_sts.last_byte ? hsb_pkg::S_STAT : hsb_pkg::S_RDH;
                end
            end
            hsb_pkg::S_STAT: begin
                if (i_sts.out_free) begin
                    o_cmd.load_stat = 1'b1;
                    n_state         = hsb_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = hsb_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/hsb_dp.sv
// datapath: scan state, digit store, byte assembly and result register
module hsb_dp #(
    parameter int MAX_BYTES = hsb_pkg::MAX_BYTES_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  hsb_pkg::t_cmd i_cmd,
    output hsb_pkg::t_sts o_sts,
    input  logic [7:0]    i_character,
    input  logic          i_cfg_valid,
    input  logic [5:0]    i_cfg_max_bytes,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output logic          o_kind,
    output logic [7:0]    o_byte_value,
    output logic [2:0]    o_status,
    output logic [5:0]    o_byte_total,
    output logic          o_last
);

    localparam int         DEPTH   = 2 * MAX_BYTES;
    localparam int         AW      = $clog2(DEPTH);
    localparam logic [6:0] DEPTH_L = 7'(DEPTH);
    localparam logic [5:0] MAX_L   = 6'(MAX_BYTES);
    localparam int         DW      = hsb_pkg::DIGIT_W;

    // scan state
    hsb_pkg::t_phase r_phase, n_phase;
    logic [6:0]      r_len, n_len;
    logic            r_pend, n_pend;
    logic            r_nonsp, n_nonsp;
    logic            r_bad_vld, n_bad_vld;
    logic [AW-1:0]   r_bad_idx, n_bad_idx;
    logic [5:0]      r_max;

    // finish results
    logic            r_pad;
    logic [5:0]      r_num;
    logic [2:0]      r_stat;
    logic [5:0]      r_total;
    logic [5:0]      r_k;
    logic [3:0]      r_hi;

    // result register
    logic            r_ov;
    logic            r_kind;
    logic [7:0]      r_byte;
    logic [2:0]      r_ostat;
    logic [5:0]      r_otot;
    logic            r_last;

    // store port signals
    logic            we;
    logic [6:0]      wpos;
    logic [DW-1:0]   wdata;
    logic            push;
    logic [6:0]      rd_v;
    logic [6:0]      rd_pos;
    logic [DW-1:0]   rdata;

    // character classification
    logic            c_ws;
    logic            c_x;
    logic            c_zero;
    logic [DW-1:0]   c_dig;

    // finish arithmetic
    logic [5:0]      f_cnt;
    logic [7:0]      f_len_r;
    logic [6:0]      f_half_up;
    logic [5:0]      f_half;
    logic            f_pad;
    logic [5:0]      f_num;
    logic [6:0]      f_used;
    logic [6:0]      f_limit;
    logic            f_bad;
    logic            f_trunc;
    logic            f_none;
    logic [2:0]      f_stat;
    logic            out_free;

    assign c_ws   = hsb_pkg::is_ws(i_character);
    assign c_x    = (i_character == hsb_pkg::CH_X_LO) || (i_character == hsb_pkg::CH_X_UP);
    assign c_zero = (i_character == hsb_pkg::CH_ZERO);
    assign c_dig  = hsb_pkg::to_digit(i_character);

    // character scan and end-of-string handling
    always_comb begin
        n_phase   = r_phase;
        n_len     = r_len;
        n_pend    = r_pend;
        n_nonsp   = r_nonsp;
        n_bad_vld = r_bad_vld;
        n_bad_idx = r_bad_idx;
        we        = 1'b0;
        wpos      = r_len;
        wdata     = c_dig;
        push      = 1'b0;
        if (i_cmd.take_char) begin
            case (r_phase)
                hsb_pkg::PH_LEAD: begin
                    if (r_pend) begin
                        // zero already sits in entry 0; x drops it as a prefix
                        n_pend  = 1'b0;
                        n_phase = hsb_pkg::PH_TOKEN;
                        if (!c_x) begin
                            n_len = 7'd1;
                            if (c_ws) begin
                                n_phase = hsb_pkg::PH_TAIL;
                            end else begin
                                push = 1'b1;
                                wpos = 7'd1;
                            end
                        end
                    end else if (!c_ws) begin
                        if (c_zero) begin
                            n_pend = 1'b1;
                            we     = 1'b1;
                            wpos   = 7'd0;
                            wdata  = hsb_pkg::DIGIT_ZERO;
                        end else begin
                            n_phase = hsb_pkg::PH_TOKEN;
                            push    = 1'b1;
                        end
                    end
                end
                hsb_pkg::PH_TOKEN: begin
                    if (c_ws) begin
                        n_phase = hsb_pkg::PH_TAIL;
                    end else begin
                        push = 1'b1;
                    end
                end
                hsb_pkg::PH_TAIL: begin
                    if (!c_ws) begin
                        n_nonsp = 1'b1;
                    end
                end
                default: begin
                    n_phase = hsb_pkg::PH_LEAD;
                end
            endcase
            if (push) begin
                if (wpos < DEPTH_L) begin
                    we = 1'b1;
                    if (c_dig[DW-1] && !r_bad_vld) begin
                        n_bad_vld = 1'b1;
                        n_bad_idx = wpos[AW-1:0];
                    end
                end
                if (wpos < hsb_pkg::LEN_CAP) begin
                    n_len = wpos + 7'd1;
                end
            end
        end
        // a lone leading zero becomes the token
        if (i_cmd.take_end && r_pend) begin
            n_pend  = 1'b0;
            n_len   = 7'd1;
            n_phase = hsb_pkg::PH_TOKEN;
        end
        // rearm for the next string
        if (i_cmd.calc) begin
            n_phase   = hsb_pkg::PH_LEAD;
            n_len     = 7'd0;
            n_pend    = 1'b0;
            n_nonsp   = 1'b0;
            n_bad_vld = 1'b0;
        end
    end

    // byte count, padding and status at end of string
    always_comb begin
        f_cnt     = (r_max > MAX_L) ? MAX_L : r_max;
        f_len_r   = {1'b0, r_len} + 8'd1;
        f_half_up = f_len_r[7:1];
        f_half    = r_len[6:1];
        f_pad     = r_len[0] && ({1'b0, f_cnt} >= f_half_up);
        if (f_pad) begin
            f_num = f_half_up[5:0];
        end else begin
            f_num = (f_half > f_cnt) ? f_cnt : f_half;
        end
        f_used  = {f_num, 1'b0};
        f_limit = f_pad ? r_len : f_used;
        f_bad   = r_bad_vld && (7'(r_bad_idx) < f_limit);
        f_trunc = !f_pad && (f_used < r_len);
        f_none  = (f_cnt == 6'd0) || (r_len == 7'd0) || f_bad;
        if (f_cnt == 6'd0) begin
            f_stat = hsb_pkg::ST_BAD;
        end else if (r_len == 7'd0) begin
            f_stat = hsb_pkg::ST_EMPTY;
        end else if (f_bad) begin
            f_stat = hsb_pkg::ST_BAD;
        end else if (f_trunc) begin
            f_stat = hsb_pkg::ST_TRAIL;
        end else if (r_phase == hsb_pkg::PH_TAIL) begin
            f_stat = r_nonsp ? hsb_pkg::ST_TRAIL : hsb_pkg::ST_SPACES;
        end else begin
            f_stat = hsb_pkg::ST_END;
        end
    end

    // store read address: padding shifts stored digits by one
    assign rd_v   = {r_k, 1'b0} + (i_cmd.sel_hi ? 7'd0 : 7'd1);
    assign rd_pos = r_pad ? (rd_v - 7'd1) : rd_v;

    hsb_ram #(
        .WIDTH (DW),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (wpos[AW-1:0]),
        .i_wdata (wdata),
        .i_raddr (rd_pos[AW-1:0]),
        .o_rdata (rdata)
    );

    assign out_free = !r_ov || i_out_ready;

    // scan state and limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= hsb_pkg::PH_LEAD;
            r_len     <= 7'd0;
            r_pend    <= 1'b0;
            r_nonsp   <= 1'b0;
            r_bad_vld <= 1'b0;
            r_max     <= hsb_pkg::MAX_BYTES_RST;
        end else begin
            r_phase   <= n_phase;
            r_len     <= n_len;
            r_pend    <= n_pend;
            r_nonsp   <= n_nonsp;
            r_bad_vld <= n_bad_vld;
            if (i_cfg_valid) begin
                r_max <= i_cfg_max_bytes;
            end
        end
    end

    // bad digit position, finish results and byte assembly
    always_ff @(posedge i_clk) begin
        r_bad_idx <= n_bad_idx;
        if (i_cmd.calc) begin
            r_pad   <= f_pad;
            r_num   <= f_num;
            r_stat  <= f_stat;
            r_total <= f_none ? 6'd0 : f_num;
            r_k     <= 6'd0;
        end else if (i_cmd.load_byte) begin
            r_k <= r_k + 6'd1;
        end
        if (i_cmd.cap_hi) begin
            r_hi <= (r_pad && (r_k == 6'd0)) ? 4'd0 : rdata[3:0];
        end
    end

    // result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.load_byte || i_cmd.load_stat) begin
            r_ov <= 1'b1;
        end else if (i_out_ready) begin
            r_ov <= 1'b0;
        end
    end

    // result register payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_byte) begin
            r_kind  <= 1'b0;
            r_byte  <= {r_hi, rdata[3:0]};
            r_ostat <= hsb_pkg::ST_END;
            r_otot  <= 6'd0;
            r_last  <= 1'b0;
        end else if (i_cmd.load_stat) begin
            r_kind  <= 1'b1;
            r_byte  <= 8'h00;
            r_ostat <= r_stat;
            r_otot  <= r_total;
            r_last  <= 1'b1;
        end
    end

    assign o_sts.out_free  = out_free;
    assign o_sts.no_bytes  = f_none;
    assign o_sts.last_byte = ((r_k + 6'd1) == r_num);

    assign o_out_valid  = r_ov;
    assign o_kind       = r_kind;
    assign o_byte_value = r_byte;
    assign o_status     = r_ostat;
    assign o_byte_total = r_otot;
    assign o_last       = r_last;

endmodule

// File: rtl/hex_string_to_bytes_top.sv
// top level of the hex string to byte array parser
//
// Input channel (i_in_valid / o_in_ready) carries one character per transfer;
// a transfer with i_end_of_string set closes the string. Characters are taken
// one per cycle while the block is idle and cost no result. Leading whitespace
// and an optional 0x/0X prefix are skipped, the hex token is kept in a
// 2*MAX_BYTES entry digit ram. After the end marker the block computes the
// byte count in S_CALC, then emits each byte through S_RDH, S_RDL and S_LOAD
// (two ram reads and a load), and finally one status item with o_last set.
// A string with an error or no token yields the status item only.
// Output channel (o_out_valid / i_out_ready) is a single result register; a
// stalled receiver holds emission, while after the status item is loaded the
// next string's characters are already accepted.
// Config channel (i_cfg_valid / o_cfg_ready) writes max_bytes, always ready;
// write it only while the block is idle.
// Synchronous reset returns to the leading whitespace phase, empties the
// result register and sets max_bytes to 32. The ram is not cleared.
module hex_string_to_bytes_top #(
    parameter int MAX_BYTES = hsb_pkg::MAX_BYTES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_character,
    input  logic       i_end_of_string,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [5:0] i_cfg_max_bytes,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_kind,
    output logic [7:0] o_byte_value,
    output logic [2:0] o_status,
    output logic [5:0] o_byte_total,
    output logic       o_last
);

    hsb_pkg::t_cmd cmd;
    hsb_pkg::t_sts sts;

    assign o_cfg_ready = 1'b1;

    hsb_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_end_of_string (i_end_of_string),
        .i_sts           (sts),
        .o_cmd           (cmd)
    );

    hsb_dp #(
        .MAX_BYTES (MAX_BYTES)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_character     (i_character),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_max_bytes (i_cfg_max_bytes),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_kind          (o_kind),
        .o_byte_value    (o_byte_value),
        .o_status        (o_status),
        .o_byte_total    (o_byte_total),
        .o_last          (o_last)
    );

endmodule

// File: rtl/hsb_checker.sv
// port-level assertions for the hex string parser, bound to the top level
module hsb_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_ready,
    input logic       i_end_of_string,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic       o_kind,
    input logic [7:0] o_byte_value,
    input logic [2:0] o_status,
    input logic [5:0] o_byte_total,
    input logic       o_last
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_kind)
            && $stable(o_byte_value) && $stable(o_status) && $stable(o_last))
        else $error("stalled result changed");

    // only the status item closes a string
    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_kind == o_last))
        else $error("last flag does not match item kind");

    // error and empty report no bytes
    a_err_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind
            && (o_status == hsb_pkg::ST_BAD || o_status == hsb_pkg::ST_EMPTY)
            |-> (o_byte_total == 6'd0))
        else $error("byte total on error status");

    // no characters taken while data bytes are pending
    a_busy_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_kind |-> !o_in_ready)
        else $error("input ready during byte emission");

    // the end marker closes the input side for the next cycle
    a_end_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_end_of_string |=> !o_in_ready)
        else $error("input ready right after end marker");

endmodule

bind hex_string_to_bytes_top hsb_checker u_hsb_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_ready      (o_in_ready),
    .i_end_of_string (i_end_of_string),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_kind          (o_kind),
    .o_byte_value    (o_byte_value),
    .o_status        (o_status),
    .o_byte_total    (o_byte_total),
    .o_last          (o_last)
);

// File: tb/sv/tb.sv
// self-checking testbench for the hex string to byte array parser
`timescale 1ns / 100ps

module tb;

    localparam int STORE_DEPTH   = 2 * hsb_pkg::MAX_BYTES_DEF;
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES   = 40;
    localparam int CYCLE_LIMIT   = 300000;
    localparam int RAND_CHARS    = 30;
    localparam int DIR_ROWS      = 16;
    localparam int NO_EXTRA      = -1;

    // one result transfer as seen on the output channel
    typedef struct packed {
        logic       kind;
        logic [7:0] value;
        logic [2:0] status;
        logic [5:0] total;
        logic       last;
    } t_result;

    // result typed into the table: at most one byte, then the status item
    typedef struct packed {
        logic       valid;
        logic [7:0] byte0;
        logic [2:0] status;
        logic [5:0] total;
    } t_check;

    // one directed string: text, optional raw byte after it, limit, typed result
    typedef struct {
        string      text;
        int         extra;
        logic [5:0] limit;
        logic       typed;
        logic [7:0] byte0;
        logic [2:0] status;
        logic [5:0] total;
    } t_row;

    t_row dir_rows [DIR_ROWS] = '{
        '{"",             NO_EXTRA, 6'd32, 1'b1, 8'h00, hsb_pkg::ST_EMPTY,  6'd0},
        '{"ff",           NO_EXTRA, 6'd32, 1'b1, 8'hFF, hsb_pkg::ST_END,    6'd1},
        '{"0X00",         NO_EXTRA, 6'd32, 1'b1, 8'h00, hsb_pkg::ST_END,    6'd1},
        '{"  0x",         NO_EXTRA, 6'd32, 1'b1, 8'h00, hsb_pkg::ST_EMPTY,  6'd0},
        '{"\t0xa\r",      NO_EXTRA, 6'd32, 1'b0, 8'h00, hsb_pkg::ST_END,    6'd0},
        '{"0",            NO_EXTRA, 6'd32, 1'b0, 8'h00, hsb_pkg::ST_END,    6'd0},
        '{"0y",           NO_EXTRA, 6'd32, 1'b1, 8'h00, hsb_pkg::ST_BAD,    6'd0},
        '{"12",           8'h00,    6'd32, 1'b1, 8'h00, hsb_pkg::ST_BAD,    6'd0},
        '{"AB  ",         8'h80,    6'd32, 1'b1, 8'hAB, hsb_pkg::ST_TRAIL,  6'd1},
        '{"12 \n\013\014", NO_EXTRA, 6'd32, 1'b0, 8'h00, hsb_pkg::ST_END,   6'd0},
        '{"9aFfA",        NO_EXTRA, 6'd32, 1'b0, 8'h00, hsb_pkg::ST_END,    6'd0},
        '{"12",           NO_EXTRA, 6'd0,  1'b1, 8'h00, hsb_pkg::ST_BAD,    6'd0},
        '{"abz",          NO_EXTRA, 6'd1,  1'b0, 8'h00, hsb_pkg::ST_END,    6'd0},
        '{"123",          NO_EXTRA, 6'd63, 1'b0, 8'h00, hsb_pkg::ST_END,    6'd0},
        '{"12345",        NO_EXTRA, 6'd2,  1'b0, 8'h00, hsb_pkg::ST_END,    6'd0},
        '{" 0x0x",        NO_EXTRA, 6'd32, 1'b1, 8'h00, hsb_pkg::ST_BAD,    6'd0}
    };

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_ready;
    logic [7:0] i_character;
    logic       i_end_of_string;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic [5:0] i_cfg_max_bytes;
    logic       o_out_valid;
    logic       i_out_ready = 1'b0;
    logic       o_kind;
    logic [7:0] o_byte_value;
    logic [2:0] o_status;
    logic [5:0] o_byte_total;
    logic       o_last;

    // parser model state
    logic [5:0]      limit_reg = hsb_pkg::MAX_BYTES_RST;
    hsb_pkg::t_phase scan      = hsb_pkg::PH_LEAD;
    logic [4:0]      digits [STORE_DEPTH];
    logic [6:0]      ndigits   = '0;
    logic            lead_zero = 1'b0;
    logic            tail_junk = 1'b0;

    t_result parse_q [$];
    t_result new_items [$];
    t_check  table_checks [$];
    t_check  chk;
    t_result want;

    int  err_count    = 0;
    int  chars_sent   = 0;
    int  cycle_count;
    bit  steady       = 1'b0;
    int  ready_left   = 0;
    bit  ready_level  = 1'b0;
    int  stall_roll;

    hex_string_to_bytes_top u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_character     (i_character),
        .i_end_of_string (i_end_of_string),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_max_bytes (i_cfg_max_bytes),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_kind          (o_kind),
        .o_byte_value    (o_byte_value),
        .o_status        (o_status),
        .o_byte_total    (o_byte_total),
        .o_last          (o_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------- model

    function automatic bit blank_char(input logic [7:0] c);
        return c == hsb_pkg::CH_SPACE || (c >= hsb_pkg::CH_TAB && c <= hsb_pkg::CH_CR);
    endfunction

    function automatic logic [4:0] nibble_of(input logic [7:0] c);
        if (c >= hsb_pkg::CH_A_LO && c <= hsb_pkg::CH_F_LO)
            return 5'(c - hsb_pkg::CH_A_LO + 8'd10);
        if (c >= hsb_pkg::CH_A_UP && c <= hsb_pkg::CH_F_UP)
            return 5'(c - hsb_pkg::CH_A_UP + 8'd10);
        if (c >= hsb_pkg::CH_ZERO && c <= hsb_pkg::CH_NINE)
            return 5'(c - hsb_pkg::CH_ZERO);
        return hsb_pkg::DIGIT_BAD;
    endfunction

    // digit v of the token, counted after the optional zero pad
    function automatic logic [4:0] padded_digit(input int v, input bit pad);
        int idx;
        if (pad && v == 0) return hsb_pkg::DIGIT_ZERO;
        idx = pad ? v - 1 : v;
        if (idx >= STORE_DEPTH) return hsb_pkg::DIGIT_BAD;
        return digits[idx];
    endfunction

    task automatic keep_digit(input logic [7:0] c);
        if (ndigits < STORE_DEPTH) digits[ndigits] = nibble_of(c);
        if (ndigits < hsb_pkg::LEN_CAP) ndigits++;
    endtask

    task automatic token_step(input logic [7:0] c);
        if (blank_char(c)) begin
            scan = hsb_pkg::PH_TAIL;
        end else begin
            keep_digit(c);
        end
    endtask

    task automatic take_char(input logic [7:0] c);
        case (scan)
            hsb_pkg::PH_LEAD: begin
                if (lead_zero) begin
                    // a zero right before x/X is the prefix, else a digit
                    lead_zero = 1'b0;
                    scan      = hsb_pkg::PH_TOKEN;
                    if (c != hsb_pkg::CH_X_LO && c != hsb_pkg::CH_X_UP) begin
                        keep_digit(hsb_pkg::CH_ZERO);
                        token_step(c);
                    end
                end else if (!blank_char(c)) begin
                    if (c == hsb_pkg::CH_ZERO) begin
                        lead_zero = 1'b1;
                    end else begin
                        scan = hsb_pkg::PH_TOKEN;
                        keep_digit(c);
                    end
                end
            end
            hsb_pkg::PH_TOKEN: token_step(c);
            default: begin
                if (!blank_char(c)) tail_junk = 1'b1;
            end
        endcase
    endtask

    // end marker: work out the bytes and the status item, then rearm
    task automatic close_string();
        int         lim, n, len, num, used;
        bit         pad, bad;
        logic [2:0] st;
        logic [4:0] hi, lo;
        if (lead_zero) begin
            lead_zero = 1'b0;
            scan      = hsb_pkg::PH_TOKEN;
            keep_digit(hsb_pkg::CH_ZERO);
        end
        n   = ndigits;
        lim = (limit_reg > hsb_pkg::MAX_BYTES_DEF) ? hsb_pkg::MAX_BYTES_DEF : limit_reg;
        num = 0;
        bad = 1'b0;
        if (limit_reg == 0) begin
            st = hsb_pkg::ST_BAD;
        end else if (n == 0) begin
            st = hsb_pkg::ST_EMPTY;
        end else begin
            len  = n / 2 + n % 2;
            pad  = (n % 2 == 1) && lim >= len;
            num  = pad ? len : ((n / 2 > lim) ? lim : n / 2);
            used = 2 * num;
            for (int k = 0; k < used; k++) begin
                hi = padded_digit(k, pad);
                if (hi[4]) bad = 1'b1;
            end
            if (bad) begin
                st  = hsb_pkg::ST_BAD;
                num = 0;
            end else begin
                if (!pad && used < n) st = hsb_pkg::ST_TRAIL;
                else if (scan == hsb_pkg::PH_TAIL)
                    st = tail_junk ? hsb_pkg::ST_TRAIL : hsb_pkg::ST_SPACES;
                else st = hsb_pkg::ST_END;
                for (int k = 0; k < num; k++) begin
                    hi = padded_digit(2 * k, pad);
                    lo = padded_digit(2 * k + 1, pad);
                    new_items.push_back(t_result'{1'b0, {hi[3:0], lo[3:0]},
                                                  hsb_pkg::ST_END, 6'd0, 1'b0});
                end
            end
        end
        new_items.push_back(t_result'{1'b1, 8'h00, st, 6'(num), 1'b1});
        scan      = hsb_pkg::PH_LEAD;
        ndigits   = '0;
        tail_junk = 1'b0;
    endtask

    // ---------------------------------------------------------------- checking

    task automatic flag_mismatch(input string what);
        err_count++;
        $display("mismatch at %0t: %s", $time, what);
    endtask

    // watch every transfer: config, characters in, results out
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) limit_reg = i_cfg_max_bytes;
            if (i_in_valid && o_in_ready) begin
                if (!i_end_of_string) begin
                    take_char(i_character);
                end else begin
                    close_string();
                    chk = '0;
                    if (table_checks.size() != 0) chk = table_checks.pop_front();
                    if (chk.valid) begin
                        if (chk.total == 6'd1)
                            parse_q.push_back(t_result'{1'b0, chk.byte0, hsb_pkg::ST_END,
                                                        6'd0, 1'b0});
                        parse_q.push_back(t_result'{1'b1, 8'h00, chk.status, chk.total,
                                                    1'b1});
                    end else begin
                        foreach (new_items[j]) parse_q.push_back(new_items[j]);
                    end
                    new_items.delete();
                end
            end
            if (o_out_valid && i_out_ready) begin
                if (parse_q.size() == 0) begin
                    flag_mismatch("result transfer with nothing expected");
                end else begin
                    want = parse_q.pop_front();
                    if (o_kind !== want.kind)
                        flag_mismatch($sformatf("kind got %0d want %0d", o_kind, want.kind));
                    if (o_byte_value !== want.value)
                        flag_mismatch($sformatf("byte_value got %h want %h",
                                                o_byte_value, want.value));
                    if (o_status !== want.status)
                        flag_mismatch($sformatf("status got %0d want %0d",
                                                o_status, want.status));
                    if (o_byte_total !== want.total)
                        flag_mismatch($sformatf("byte_total got %0d want %0d",
                                                o_byte_total, want.total));
                    if (o_last !== want.last)
                        flag_mismatch($sformatf("last got %0d want %0d", o_last, want.last));
                end
            end
        end
    end

    // receiver: ready stretches and stalls, mostly short, a few long
    always @(posedge i_clk) begin
        if (ready_left == 0) begin
            stall_roll = $urandom_range(0, 99);
            if (stall_roll < 50) begin
                ready_level = 1'b1;
                ready_left  = $urandom_range(1, 10);
            end else if (stall_roll < 60) begin
                ready_level = 1'b1;
                ready_left  = $urandom_range(30, 80);
            end else if (stall_roll < 88) begin
                ready_level = 1'b0;
                ready_left  = $urandom_range(1, 3);
            end else if (stall_roll < 97) begin
                ready_level = 1'b0;
                ready_left  = $urandom_range(4, 12);
            end else begin
                ready_level = 1'b0;
                ready_left  = $urandom_range(20, 40);
            end
        end
        ready_left--;
        i_out_ready <= ready_level;
    end

    // ---------------------------------------------------------------- stimulus

    function automatic int pick_gap();
        int r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [7:0] blank_pick();
        int v;
        v = $urandom_range(0, 5);
        return (v == 5) ? hsb_pkg::CH_SPACE : hsb_pkg::CH_TAB + 8'(v);
    endfunction

    function automatic logic [5:0] pick_limit();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) return 6'd0;
        if (r < 18) return 6'd1;
        if (r < 30) return 6'd2;
        if (r < 45) return 6'd32;
        if (r < 55) return 6'($urandom_range(33, 63));
        return 6'($urandom_range(3, 31));
    endfunction

    // one character transfer, after a random gap
    task automatic put_char(input logic [7:0] c, input logic eos);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_character     <= c;
        i_end_of_string <= eos;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        chars_sent++;
    endtask

    task automatic write_limit(input logic [5:0] v);
        i_cfg_valid     <= 1'b1;
        i_cfg_max_bytes <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // let every pending result drain, then give the block time to go idle
    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (parse_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // mostly well-formed strings with random content, some noise and damage
    task automatic send_random_string();
        logic [7:0] s [$];
        int         count, v, tok_start;
        logic [7:0] c;
        steady = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 99) < 10) begin
            count = $urandom_range(0, 8);
            repeat (count) s.push_back(8'($urandom_range(0, 255)));
        end else begin
            if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 3)) s.push_back(blank_pick());
            case ($urandom_range(0, 3))
                0: begin
                    s.push_back(hsb_pkg::CH_ZERO);
                    s.push_back(hsb_pkg::CH_X_LO);
                end
                1: begin
                    s.push_back(hsb_pkg::CH_ZERO);
                    s.push_back(hsb_pkg::CH_X_UP);
                end
                default: ;
            endcase
            v     = $urandom_range(0, 99);
            count = (v < 8) ? $urandom_range(60, 70) : (v < 16) ? 0 : $urandom_range(1, 12);
            tok_start = s.size();
            repeat (count) begin
                v = $urandom_range(0, 15);
                if (v < 10) c = hsb_pkg::CH_ZERO + 8'(v);
                else c = ($urandom_range(0, 1) ? hsb_pkg::CH_A_UP : hsb_pkg::CH_A_LO)
                         + 8'(v - 10);
                s.push_back(c);
            end
            // a stray character inside the token
            if (count > 0 && $urandom_range(0, 9) == 0)
                s[tok_start + $urandom_range(0, count - 1)] = 8'($urandom_range(0, 255));
            case ($urandom_range(0, 3))
                1: repeat ($urandom_range(1, 3)) s.push_back(blank_pick());
                2: begin
                    repeat ($urandom_range(1, 3)) s.push_back(blank_pick());
                    repeat ($urandom_range(1, 3)) s.push_back(8'($urandom_range(0, 255)));
                end
                default: ;
            endcase
        end
        foreach (s[j]) put_char(s[j], 1'b0);
        put_char(8'($urandom_range(0, 255)), 1'b1);
    endtask

    // ---------------------------------------------------------------- sequence

    initial begin
        t_row       row;
        logic [5:0] cur_limit;
        int         base_chars, nstr;
        i_rst_n         <= 1'b0;
        i_in_valid      <= 1'b0;
        i_character     <= 8'h00;
        i_end_of_string <= 1'b0;
        i_cfg_valid     <= 1'b0;
        i_cfg_max_bytes <= 6'd0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        cur_limit = hsb_pkg::MAX_BYTES_RST;

        // directed table
        for (int k = 0; k < DIR_ROWS; k++) begin
            row = dir_rows[k];
            if (row.limit != cur_limit) begin
                settle();
                write_limit(row.limit);
                cur_limit = row.limit;
            end
            steady = ($urandom_range(0, 2) == 0);
            table_checks.push_back(t_check'{row.typed, row.byte0, row.status, row.total});
            for (int i = 0; i < row.text.len(); i++) put_char(row.text[i], 1'b0);
            if (row.extra != NO_EXTRA) put_char(8'(row.extra), 1'b0);
            put_char(8'($urandom_range(0, 255)), 1'b1);
        end
        settle();

        // random phases, each under a fresh limit
        base_chars = chars_sent;
        while (chars_sent - base_chars < RAND_CHARS) begin
            write_limit(pick_limit());
            nstr = $urandom_range(2, 4);
            repeat (nstr) send_random_string();
            settle();
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (err_count == 0 && parse_q.size() == 0) begin
            $display("PASS hex_string_to_bytes_top");
        end else begin
            $display("FAIL hex_string_to_bytes_top");
        end
        $finish;
    end

    // watchdog
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("FAIL hex_string_to_bytes_top");
        $finish;
    end

endmodule
